/* rtl/core/block_color_distance_assert.svh */
// ---------------------------------------------------------------------------
// block_color_distance assertion macros
// Clocked, reset-qualified implication checks shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef BLOCK_COLOR_DISTANCE_ASSERT_SVH
`define BLOCK_COLOR_DISTANCE_ASSERT_SVH

// same-cycle implication
`define BCD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bcd_pkg.sv */
// ---------------------------------------------------------------------------
// bcd_pkg
// Widths, limits, register map and reset values of the color distance block.
// ---------------------------------------------------------------------------
package bcd_pkg;

    localparam int MAX_BLOCK_PIXELS = 4096;
    localparam int CNT_W            = $clog2(MAX_BLOCK_PIXELS + 1);

    localparam int CH_W     = 16;
    localparam int WT_W     = 16;
    localparam int WD_SHIFT = 14;
    localparam int MUL_W    = 18;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SUM_W    = 50;
    localparam int SQRT_TOP = ((SUM_W - 1) / 2) * 2;
    localparam int DIST_W   = 32;
    localparam int PIX_W    = 13;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [1:0] LAST_CH = 2'd2;

    localparam logic [CH_W:0] HUE_TURN = (CH_W + 1)'(1) << CH_W;
    localparam logic [CH_W-1:0] HUE_HALF = CH_W'(1) << (CH_W - 1);

    localparam logic [WT_W-1:0] WEIGHT_C0_RST = WT_W'(4915);
    localparam logic [WT_W-1:0] WEIGHT_C1_RST = WT_W'(9667);
    localparam logic [WT_W-1:0] WEIGHT_C2_RST = WT_W'(1802);

    typedef enum logic [2:0] {
        REG_COLOR_SPACE = 3'd0,
        REG_NORM_KIND   = 3'd1,
        REG_WEIGHT_C0   = 3'd2,
        REG_WEIGHT_C1   = 3'd3,
        REG_WEIGHT_C2   = 3'd4
    } reg_idx_t;

    typedef enum logic {
        SPACE_RGB = 1'b0,
        SPACE_HSV = 1'b1
    } color_space_t;

    typedef enum logic {
        NORM_L1 = 1'b0,
        NORM_L2 = 1'b1
    } norm_kind_t;

endpackage

/* rtl/core/block_color_distance.sv */
// ---------------------------------------------------------------------------
// block_color_distance
// Weighted L1 / L2 color distance accumulated over a block of pixel pairs.
// ---------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       slave      in_valid / in_stall   a_ch0..2, b_ch0..2, last_pixel
//  out      master     out_valid / out_stall distance, pixel_count, overflow
//  cfg      slave      APB psel / penable    paddr, pwdata, prdata
//
//  One 18x18 multiplier is shared: it weighs each channel and, in L2, squares
//  the weighed value, one channel after another. A pair beyond the block
//  bound is dropped without entering the multiplier. The last pair adds an
//  emit step, and in L2 also the bit-pair square root loop ahead of it.
//  Reset clears the sum, the count and the drop flag and loads the default
//  weights. in_stall is high whenever the sequencer is busy; a full output
//  register with out_stall high holds the sequencer at the emit step.
// ---------------------------------------------------------------------------
module block_color_distance (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bcd_pkg::CH_W-1:0]     a_ch0,
    input  logic [bcd_pkg::CH_W-1:0]     a_ch1,
    input  logic [bcd_pkg::CH_W-1:0]     a_ch2,
    input  logic [bcd_pkg::CH_W-1:0]     b_ch0,
    input  logic [bcd_pkg::CH_W-1:0]     b_ch1,
    input  logic [bcd_pkg::CH_W-1:0]     b_ch2,
    input  logic                         last_pixel,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bcd_pkg::DIST_W-1:0]   distance,
    output logic [bcd_pkg::PIX_W-1:0]    pixel_count,
    output logic                         overflow,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bcd_pkg::ADDR_W-1:0]   paddr,
    input  logic [bcd_pkg::DATA_W-1:0]   pwdata,
    output logic [bcd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WEIGH,
        ST_SQUARE,
        ST_ACC,
        ST_SQRT,
        ST_EMIT
    } state_t;

    state_t                            state_reg;

    bcd_pkg::color_space_t             color_space_reg;
    bcd_pkg::norm_kind_t               norm_kind_reg;
    logic [bcd_pkg::WT_W-1:0]          weight_c0_reg;
    logic [bcd_pkg::WT_W-1:0]          weight_c1_reg;
    logic [bcd_pkg::WT_W-1:0]          weight_c2_reg;

    logic [bcd_pkg::CH_W-1:0]          a0_reg, a1_reg, a2_reg;
    logic [bcd_pkg::CH_W-1:0]          b0_reg, b1_reg, b2_reg;
    logic                              last_reg;
    logic [1:0]                        ch_reg;
    logic [bcd_pkg::PROD_W-1:0]        prod_reg;

    logic [bcd_pkg::SUM_W-1:0]         sum_reg;
    logic [bcd_pkg::CNT_W-1:0]         pairs_reg;
    logic                              dropped_reg;
    logic [bcd_pkg::SUM_W-1:0]         root_reg;
    logic [bcd_pkg::SUM_W-1:0]         bit_reg;

    logic                              out_valid_reg;
    logic [bcd_pkg::DIST_W-1:0]        distance_reg;
    logic [bcd_pkg::PIX_W-1:0]         pixel_count_reg;
    logic                              overflow_reg;

    logic [bcd_pkg::CH_W-1:0]          a_sel, b_sel, abs_d, chan_d;
    logic [bcd_pkg::WT_W-1:0]          w_sel;
    logic [bcd_pkg::MUL_W-1:0]         wd;
    logic [bcd_pkg::MUL_W-1:0]         mul_a, mul_b;
    logic [bcd_pkg::PROD_W-1:0]        prod_next;
    logic [bcd_pkg::PROD_W-1:0]        term;
    logic [bcd_pkg::SUM_W:0]           sum_add;
    logic [bcd_pkg::SUM_W-1:0]         sum_next;
    logic [bcd_pkg::SUM_W:0]           trial;
    logic                              trial_ge;
    logic [bcd_pkg::SUM_W-1:0]         rem_next;
    logic [bcd_pkg::SUM_W-1:0]         root_next;
    logic [bcd_pkg::DIST_W-1:0]        dist_next;
    state_t                            finish_state;
    logic                              in_take;
    logic                              emit_ok;
    logic                              cfg_wr;
    bcd_pkg::reg_idx_t                 cfg_idx;

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_take     = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign distance    = distance_reg;
    assign pixel_count = pixel_count_reg;
    assign overflow    = overflow_reg;
    assign pready      = 1'b1;
    assign emit_ok     = !out_valid_reg || !out_stall;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = bcd_pkg::reg_idx_t'(paddr[bcd_pkg::ADDR_W-1:2]);

    always_comb
    begin
        case (cfg_idx)
            bcd_pkg::REG_COLOR_SPACE: prdata = bcd_pkg::DATA_W'(color_space_reg);
            bcd_pkg::REG_NORM_KIND:   prdata = bcd_pkg::DATA_W'(norm_kind_reg);
            bcd_pkg::REG_WEIGHT_C0:   prdata = bcd_pkg::DATA_W'(weight_c0_reg);
            bcd_pkg::REG_WEIGHT_C1:   prdata = bcd_pkg::DATA_W'(weight_c1_reg);
            bcd_pkg::REG_WEIGHT_C2:   prdata = bcd_pkg::DATA_W'(weight_c2_reg);
            default:                  prdata = '0;
        endcase
    end

    // channel difference and weight select
    always_comb
    begin
        case (ch_reg)
            2'd0:
            begin
                a_sel = a0_reg;
                b_sel = b0_reg;
                w_sel = weight_c0_reg;
            end
            2'd1:
            begin
                a_sel = a1_reg;
                b_sel = b1_reg;
                w_sel = weight_c1_reg;
            end
            default:
            begin
                a_sel = a2_reg;
                b_sel = b2_reg;
                w_sel = weight_c2_reg;
            end
        endcase
        abs_d = (a_sel >= b_sel) ? (a_sel - b_sel) : (b_sel - a_sel);
        if (ch_reg == 2'd0 && color_space_reg == bcd_pkg::SPACE_HSV
            && abs_d > bcd_pkg::HUE_HALF)
        begin
            chan_d = bcd_pkg::CH_W'(bcd_pkg::HUE_TURN - {1'b0, abs_d});
        end
        else
        begin
            chan_d = abs_d;
        end
    end

    // shared multiplier
    assign wd = prod_reg[bcd_pkg::WD_SHIFT +: bcd_pkg::MUL_W];

    always_comb
    begin
        if (state_reg == ST_SQUARE)
        begin
            mul_a = wd;
            mul_b = wd;
        end
        else
        begin
            mul_a = bcd_pkg::MUL_W'(chan_d);
            mul_b = bcd_pkg::MUL_W'(w_sel);
        end
        prod_next = mul_a * mul_b;
    end

    // saturating accumulate
    always_comb
    begin
        term     = (norm_kind_reg == bcd_pkg::NORM_L2) ? prod_reg
                                                       : bcd_pkg::PROD_W'(wd);
        sum_add  = {1'b0, sum_reg} + (bcd_pkg::SUM_W + 1)'(term);
        sum_next = sum_add[bcd_pkg::SUM_W] ? '1 : sum_add[bcd_pkg::SUM_W-1:0];
    end

    // one square root step, remainder lives in sum_reg
    always_comb
    begin
        trial     = {1'b0, root_reg} + {1'b0, bit_reg};
        trial_ge  = ({1'b0, sum_reg} >= trial);
        rem_next  = trial_ge ? (sum_reg - trial[bcd_pkg::SUM_W-1:0]) : sum_reg;
        root_next = trial_ge ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
    end

    always_comb
    begin
        if (norm_kind_reg == bcd_pkg::NORM_L2)
        begin
            dist_next    = root_reg[bcd_pkg::DIST_W-1:0];
            finish_state = ST_SQRT;
        end
        else
        begin
            dist_next    = (|sum_reg[bcd_pkg::SUM_W-1:bcd_pkg::DIST_W])
                           ? '1 : sum_reg[bcd_pkg::DIST_W-1:0];
            finish_state = ST_EMIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            color_space_reg <= bcd_pkg::SPACE_RGB;
            norm_kind_reg   <= bcd_pkg::NORM_L1;
            weight_c0_reg   <= bcd_pkg::WEIGHT_C0_RST;
            weight_c1_reg   <= bcd_pkg::WEIGHT_C1_RST;
            weight_c2_reg   <= bcd_pkg::WEIGHT_C2_RST;
            a0_reg          <= '0;
            a1_reg          <= '0;
            a2_reg          <= '0;
            b0_reg          <= '0;
            b1_reg          <= '0;
            b2_reg          <= '0;
            last_reg        <= 1'b0;
            ch_reg          <= '0;
            prod_reg        <= '0;
            sum_reg         <= '0;
            pairs_reg       <= '0;
            dropped_reg     <= 1'b0;
            root_reg        <= '0;
            bit_reg         <= '0;
            out_valid_reg   <= 1'b0;
            distance_reg    <= '0;
            pixel_count_reg <= '0;
            overflow_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_idx)
                    bcd_pkg::REG_COLOR_SPACE:
                        color_space_reg <= bcd_pkg::color_space_t'(pwdata[0]);
                    bcd_pkg::REG_NORM_KIND:
                        norm_kind_reg <= bcd_pkg::norm_kind_t'(pwdata[0]);
                    bcd_pkg::REG_WEIGHT_C0:
                        weight_c0_reg <= pwdata[bcd_pkg::WT_W-1:0];
                    bcd_pkg::REG_WEIGHT_C1:
                        weight_c1_reg <= pwdata[bcd_pkg::WT_W-1:0];
                    bcd_pkg::REG_WEIGHT_C2:
                        weight_c2_reg <= pwdata[bcd_pkg::WT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (out_valid_reg && !out_stall && state_reg != ST_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        a0_reg   <= a_ch0;
                        a1_reg   <= a_ch1;
                        a2_reg   <= a_ch2;
                        b0_reg   <= b_ch0;
                        b1_reg   <= b_ch1;
                        b2_reg   <= b_ch2;
                        last_reg <= last_pixel;
                        ch_reg   <= '0;
                        root_reg <= '0;
                        bit_reg  <= bcd_pkg::SUM_W'(1) << bcd_pkg::SQRT_TOP;
                        if (pairs_reg >= bcd_pkg::CNT_W'(bcd_pkg::MAX_BLOCK_PIXELS))
                        begin
                            dropped_reg <= 1'b1;
                            state_reg   <= last_pixel ? finish_state : ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_WEIGH;
                        end
                    end
                end
                ST_WEIGH:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= (norm_kind_reg == bcd_pkg::NORM_L2) ? ST_SQUARE
                                                                     : ST_ACC;
                end
                ST_SQUARE:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    sum_reg <= sum_next;
                    if (ch_reg == bcd_pkg::LAST_CH)
                    begin
                        pairs_reg <= pairs_reg + 1'b1;
                        state_reg <= last_reg ? finish_state : ST_IDLE;
                    end
                    else
                    begin
                        ch_reg    <= ch_reg + 1'b1;
                        state_reg <= ST_WEIGH;
                    end
                end
                ST_SQRT:
                begin
                    sum_reg  <= rem_next;
                    root_reg <= root_next;
                    bit_reg  <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_ok)
                    begin
                        out_valid_reg   <= 1'b1;
                        distance_reg    <= dist_next;
                        pixel_count_reg <= bcd_pkg::PIX_W'(pairs_reg);
                        overflow_reg    <= dropped_reg;
                        sum_reg         <= '0;
                        pairs_reg       <= '0;
                        dropped_reg     <= 1'b0;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`include "block_color_distance_assert.svh"

    `BCD_ASSERT_IMPLY(a_pairs_bound, 1'b1,
        pairs_reg <= bcd_pkg::CNT_W'(bcd_pkg::MAX_BLOCK_PIXELS),
        "pair count beyond block bound")
    `BCD_ASSERT_IMPLY(a_sqrt_bit, state_reg == ST_SQRT, $onehot(bit_reg),
        "square root bit not one-hot")
    `BCD_ASSERT_IMPLY(a_out_rise, $rose(out_valid_reg), $past(state_reg) == ST_EMIT,
        "result appeared outside emit step")
    `BCD_ASSERT_IMPLY(a_drop_count, out_valid_reg && overflow_reg,
        pixel_count_reg == bcd_pkg::PIX_W'(bcd_pkg::MAX_BLOCK_PIXELS),
        "overflow flagged on a short block")
    `BCD_ASSERT_NEXT(a_emit_clears, state_reg == ST_EMIT && emit_ok,
        pairs_reg == '0 && !dropped_reg && sum_reg == '0,
        "accumulators not cleared after emit")

endmodule

/* tb/block_color_distance_test.sv */
// ----------------------------------------------------------------------------
// block_color_distance_test
// Streams pixel pairs through the color distance block under RGB/HSV, L1/L2
// and a spread of weights, predicts every block result from a local copy of
// the settings and accumulators, and compares each result beat by field.
// Covers hue wrap, zero and full-scale weights, mid-block setting changes,
// register read-back and output back pressure deep enough to stall the input.
// ----------------------------------------------------------------------------
module block_color_distance_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bcd_pkg::*;

    localparam int unsigned SETTLE_CYCLES  = 48;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES    = 400;

    localparam logic [WT_W-1:0] UNIT_WEIGHT = WT_W'(16384);
    localparam logic [WT_W-1:0] FULL_WEIGHT = '1;
    localparam logic [WT_W-1:0] ZERO_WEIGHT = '0;

    localparam logic [2:0] REG_SPARE_A = 3'd5;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    localparam logic [63:0] SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;
    localparam logic [63:0] DIST_CEIL = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0][CH_W-1:0] a;
        logic [2:0][CH_W-1:0] b;
        logic                 last;
    } pixel_pair_t;

    typedef struct packed {
        logic [DIST_W-1:0] dist_val;
        logic [PIX_W-1:0]  count;
        logic              dropped;
    } block_result_t;

    class color_distance_board;
        color_space_t     space;
        norm_kind_t       norm;
        logic [WT_W-1:0]  weight [3];
        logic [SUM_W-1:0] sum;
        int unsigned      seen;
        logic             dropped;
        block_result_t    expected_q [$];
        int unsigned      mismatches;
        int unsigned      pairs_noted;
        int unsigned      blocks_checked;

        function new();
            space          = SPACE_RGB;
            norm           = NORM_L1;
            weight[0]      = WEIGHT_C0_RST;
            weight[1]      = WEIGHT_C1_RST;
            weight[2]      = WEIGHT_C2_RST;
            sum            = '0;
            seen           = 0;
            dropped        = 1'b0;
            mismatches     = 0;
            pairs_noted    = 0;
            blocks_checked = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_COLOR_SPACE: space = color_space_t'(value[0]);
                REG_NORM_KIND:   norm = norm_kind_t'(value[0]);
                REG_WEIGHT_C0:   weight[0] = value[WT_W-1:0];
                REG_WEIGHT_C1:   weight[1] = value[WT_W-1:0];
                REG_WEIGHT_C2:   weight[2] = value[WT_W-1:0];
                default: ;
            endcase
        endfunction

        function void check_reg(logic [2:0] idx, logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            case (idx)
                REG_COLOR_SPACE: want = DATA_W'(space);
                REG_NORM_KIND:   want = DATA_W'(norm);
                REG_WEIGHT_C0:   want = DATA_W'(weight[0]);
                REG_WEIGHT_C1:   want = DATA_W'(weight[1]);
                REG_WEIGHT_C2:   want = DATA_W'(weight[2]);
                default:         return;
            endcase
            if (got !== want)
            begin
                $display("%0t: register %0d read expected %0d got %0d", $time, idx, want, got);
                mismatches++;
            end
        endfunction

        function logic [MUL_W-1:0] weighed(logic [CH_W-1:0] x, logic [CH_W-1:0] y,
                                           logic [WT_W-1:0] w, bit circular);
            logic [CH_W:0] d;
            logic [31:0]   prod;
            d = (x >= y) ? x - y : y - x;
            if (circular && d > HUE_HALF)
                d = HUE_TURN - d;
            prod = d * w;
            return prod[WD_SHIFT +: MUL_W];
        endfunction

        function logic [DIST_W-1:0] floor_root(logic [SUM_W-1:0] v);
            logic [63:0] root;
            logic [63:0] trial;
            int          i;
            root = '0;
            for (i = DIST_W - 1; i >= 0; i--)
            begin
                trial = root | (64'd1 << i);
                if (trial * trial <= 64'(v))
                    root = trial;
            end
            return root[DIST_W-1:0];
        endfunction

        function void note_pair(pixel_pair_t p);
            logic [MUL_W-1:0] wd [3];
            logic [63:0]      gain;
            logic [63:0]      total;
            block_result_t    r;
            int               c;
            pairs_noted++;
            if (seen >= MAX_BLOCK_PIXELS)
                dropped = 1'b1;
            else
            begin
                for (c = 0; c < 3; c++)
                    wd[c] = weighed(p.a[c], p.b[c], weight[c], c == 0 && space == SPACE_HSV);
                if (norm == NORM_L2)
                    gain = 64'(wd[0]) * wd[0] + 64'(wd[1]) * wd[1] + 64'(wd[2]) * wd[2];
                else
                    gain = 64'(wd[0]) + wd[1] + wd[2];
                total = 64'(sum) + gain;
                sum = (total > SUM_LIMIT) ? SUM_LIMIT[SUM_W-1:0] : total[SUM_W-1:0];
                seen++;
            end
            if (p.last)
            begin
                if (norm == NORM_L2)
                    r.dist_val = floor_root(sum);
                else
                    r.dist_val = (64'(sum) > DIST_CEIL) ? '1 : sum[DIST_W-1:0];
                r.count   = PIX_W'(seen);
                r.dropped = dropped;
                expected_q.push_back(r);
                sum     = '0;
                seen    = 0;
                dropped = 1'b0;
            end
        endfunction

        function void check_result(logic [DIST_W-1:0] got_dist, logic [PIX_W-1:0] count,
                                   logic ovf);
            block_result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result distance %0d count %0d overflow %0b",
                         $time, got_dist, count, ovf);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            blocks_checked++;
            if (got_dist !== want.dist_val)
            begin
                $display("%0t: distance expected %0d got %0d", $time, want.dist_val,
                         got_dist);
                mismatches++;
            end
            if (count !== want.count)
            begin
                $display("%0t: pixel_count expected %0d got %0d", $time, want.count, count);
                mismatches++;
            end
            if (ovf !== want.dropped)
            begin
                $display("%0t: overflow expected %0b got %0b", $time, want.dropped, ovf);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [CH_W-1:0]     a_ch0;
    logic [CH_W-1:0]     a_ch1;
    logic [CH_W-1:0]     a_ch2;
    logic [CH_W-1:0]     b_ch0;
    logic [CH_W-1:0]     b_ch1;
    logic [CH_W-1:0]     b_ch2;
    logic                last_pixel;
    logic                out_valid;
    logic                out_stall;
    logic [DIST_W-1:0]   distance;
    logic [PIX_W-1:0]    pixel_count;
    logic                overflow;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    color_distance_board board = new();
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_request  = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned setting_changes = 0;

    block_color_distance DUT (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(distance, pixel_count, overflow);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    function automatic pixel_pair_t make_pair(logic [CH_W-1:0] a0, logic [CH_W-1:0] a1,
                                              logic [CH_W-1:0] a2, logic [CH_W-1:0] b0,
                                              logic [CH_W-1:0] b1, logic [CH_W-1:0] b2,
                                              logic last);
        pixel_pair_t p;
        p.a    = {a2, a1, a0};
        p.b    = {b2, b1, b0};
        p.last = last;
        return p;
    endfunction

    function automatic logic [CH_W-1:0] random_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    function automatic logic [WT_W-1:0] random_weight();
        case ($urandom_range(0, 5))
            0:       return ZERO_WEIGHT;
            1:       return UNIT_WEIGHT;
            2:       return FULL_WEIGHT;
            default: return WT_W'($urandom);
        endcase
    endfunction

    function automatic pixel_pair_t random_pair(logic last);
        pixel_pair_t p;
        int          c;
        for (c = 0; c < 3; c++)
        begin
            p.a[c] = random_level();
            p.b[c] = random_level();
        end
        if ($urandom_range(0, 5) == 0)
            p.b[0] = p.a[0] + HUE_HALF + CH_W'($urandom_range(0, 4)) - CH_W'(2);
        p.last = last;
        return p;
    endfunction

    task automatic send_pair(input pixel_pair_t p);
        int unsigned gap;
        gap = 0;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 16);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        a_ch0      <= p.a[0];
        a_ch1      <= p.a[1];
        a_ch2      <= p.a[2];
        b_ch0      <= p.b[0];
        b_ch1      <= p.b[1];
        b_ch2      <= p.b[2];
        last_pixel <= p.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_pair(p);
    endtask

    task automatic send_run(input int unsigned n, input logic close);
        int unsigned i;
        for (i = 0; i < n; i++)
            send_pair(random_pair(close && i == n - 1));
    endtask

    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic program_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.write_reg(idx, value);
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.check_reg(idx, prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reconfigure(input color_space_t space, input norm_kind_t norm,
                               input logic [WT_W-1:0] w0, input logic [WT_W-1:0] w1,
                               input logic [WT_W-1:0] w2);
        settle_block();
        program_reg(REG_COLOR_SPACE, DATA_W'(space));
        program_reg(REG_NORM_KIND, DATA_W'(norm));
        program_reg(REG_WEIGHT_C0, DATA_W'(w0));
        program_reg(REG_WEIGHT_C1, DATA_W'(w1));
        program_reg(REG_WEIGHT_C2, DATA_W'(w2));
        setting_changes++;
    endtask

    task automatic random_phase(input int unsigned quota);
        int unsigned sent;
        int unsigned len;
        int unsigned cut;
        sent = 0;
        while (sent < quota)
        begin
            if ($urandom_range(0, 5) == 0)
                reconfigure(color_space_t'($urandom_range(0, 1)),
                            norm_kind_t'($urandom_range(0, 1)),
                            random_weight(), random_weight(), random_weight());
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            if (len > 1 && $urandom_range(0, 9) == 0)
            begin
                cut = $urandom_range(1, len - 1);
                send_run(cut, 1'b0);
                reconfigure(color_space_t'($urandom_range(0, 1)),
                            norm_kind_t'($urandom_range(0, 1)),
                            random_weight(), random_weight(), random_weight());
                send_run(len - cut, 1'b1);
            end
            else
                send_run(len, 1'b1);
            sent += len;
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        a_ch0      = '0;
        a_ch1      = '0;
        a_ch2      = '0;
        b_ch0      = '0;
        b_ch1      = '0;
        b_ch2      = '0;
        last_pixel = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: RGB, L1, default weights
        send_pair(make_pair('0, '0, '0, '0, '0, '0, 1'b1));
        send_pair(make_pair('1, '1, '1, '0, '0, '0, 1'b1));
        send_pair(make_pair('0, '0, '0, '1, '1, '1, 1'b1));

        // hue wrap around the half turn
        reconfigure(SPACE_HSV, NORM_L1, UNIT_WEIGHT, UNIT_WEIGHT, UNIT_WEIGHT);
        send_pair(make_pair(16'h0000, 16'h1234, 16'h0000, 16'hFFFF, 16'h0234, 16'hFFFF, 1'b0));
        send_pair(make_pair(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b0));
        send_pair(make_pair(16'h8001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        send_pair(make_pair(16'hFFFF, 16'hAAAA, 16'h5555, 16'h7FFF, 16'h5555, 16'hAAAA, 1'b1));

        reconfigure(SPACE_HSV, NORM_L2, FULL_WEIGHT, FULL_WEIGHT, FULL_WEIGHT);
        send_pair(make_pair(16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h0000, 16'h0000, 1'b0));
        send_pair(make_pair(16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));

        reconfigure(SPACE_RGB, NORM_L2, ZERO_WEIGHT, UNIT_WEIGHT, FULL_WEIGHT);
        send_pair(make_pair('1, '1, '1, '0, '0, '0, 1'b1));

        // switch norm and weights in the middle of a block
        reconfigure(SPACE_RGB, NORM_L1, WEIGHT_C0_RST, WEIGHT_C1_RST, WEIGHT_C2_RST);
        send_pair(make_pair(16'h1000, 16'h2000, 16'h3000, 16'h0100, 16'h0200, 16'h0300, 1'b0));
        send_pair(make_pair(16'h0001, 16'hFFFE, 16'h8000, 16'hFFFF, 16'h0001, 16'h7FFF, 1'b0));
        reconfigure(SPACE_HSV, NORM_L2, UNIT_WEIGHT, FULL_WEIGHT, ZERO_WEIGHT);
        send_pair(make_pair(16'hF000, 16'h4000, 16'h2000, 16'h1000, 16'h0000, 16'hE000, 1'b1));

        // writes to unmapped registers leave the settings alone
        settle_block();
        program_reg(REG_SPARE_A, '1);
        program_reg(REG_SPARE_B, DATA_W'(1));
        send_pair(make_pair(16'd100, 16'd200, 16'd300, 16'd50, 16'd20, 16'd10, 1'b1));

        send_idle_pct = 25;
        recv_idle_pct = 56;
        random_phase(420);

        send_idle_pct = 56;
        recv_idle_pct = 25;
        random_phase(420);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        settle_block();
        hold_request = HOLD_CYCLES;
        repeat (30)
            send_run(1, 1'b1);
        random_phase(400);

        settle_block();
        $display("checked %0d block results from %0d pixel pairs",
                 board.blocks_checked, board.pairs_noted);
        $display("%0d setting changes over RGB/HSV, L1/L2 and zero to full-scale weights",
                 setting_changes);
        if (board.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
